// ===== hdl/binary_max_heap_priority_queue_top_macros.svh =====
// Assertion macros for the priority queue checker.
`ifndef BINARY_MAX_HEAP_PRIORITY_QUEUE_TOP_MACROS_SVH
`define BINARY_MAX_HEAP_PRIORITY_QUEUE_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define BMHPQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define BMHPQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/bmhpq_pkg.sv =====
`default_nettype none

package bmhpq_pkg;

    localparam int DEPTH      = 16;
    localparam int PRIO_BITS  = 8;
    localparam int DATA_BITS  = 32;
    localparam int IDX_BITS   = $clog2(DEPTH);
    localparam int CNT_BITS   = $clog2(DEPTH + 1);
    localparam int ENTRY_BITS = PRIO_BITS + DATA_BITS;

    typedef struct packed {
        logic [PRIO_BITS-1:0] prio;
        logic [DATA_BITS-1:0] data;
    } entry_t;

    localparam logic REQ_ENQ = 1'b0;
    localparam logic REQ_DEQ = 1'b1;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    localparam logic [CNT_BITS-1:0] COUNT_FULL = CNT_BITS'(DEPTH);

endpackage

`default_nettype wire

// ===== hdl/bmhpq_ram.sv =====
`default_nettype none

module bmhpq_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 16,
    parameter int ADDR_BITS = $clog2(DEPTH)
) (
    input  wire logic                 clk,
    input  wire logic                 we,
    input  wire logic [ADDR_BITS-1:0] waddr,
    input  wire logic [WIDTH-1:0]     wdata,
    input  wire logic [ADDR_BITS-1:0] raddr_a,
    input  wire logic [ADDR_BITS-1:0] raddr_b,
    output logic      [WIDTH-1:0]     rdata_a,
    output logic      [WIDTH-1:0]     rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

`default_nettype wire

// ===== hdl/binary_max_heap_priority_queue_top.sv =====
// Binary max-heap priority queue, 16 entries of (priority, data).
// Input channel: in_valid / in_stall carry one request per beat: req_type
// selects enqueue (entry_priority, entry_data) or dequeue. Output channel:
// out_valid / out_stall carry one result beat per request with the
// dequeued entry, status and the count, empty and full flags after it.
// One request is worked at a time; in_stall is high from acceptance until
// the result is handed to the output register.
// Enqueue walks ST_UP_RD and ST_UP_CMP up the heap; dequeue reads the root
// and last slot (ST_DN_RD0, ST_DN_TAKE), then walks ST_DN_RD and ST_DN_CMP
// down. A full enqueue or an empty dequeue goes straight to ST_DONE. Each
// heap level costs a memory read state and a compare-and-write state.
// The output register holds a result while out_stall is high; the next
// request is still accepted, and its result waits until the register frees.
// Reset empties the heap and drops any pending result; the entry memory is
// not cleared, since only slots below the count are ever used.
`default_nettype none

module binary_max_heap_priority_queue_top (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic                           req_type,
    input  wire logic [bmhpq_pkg::PRIO_BITS-1:0] entry_priority,
    input  wire logic [bmhpq_pkg::DATA_BITS-1:0] entry_data,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic      [bmhpq_pkg::PRIO_BITS-1:0] out_priority,
    output logic      [bmhpq_pkg::DATA_BITS-1:0] out_data,
    output logic      [1:0]                     status,
    output logic      [bmhpq_pkg::CNT_BITS-1:0]  count,
    output logic                                is_empty,
    output logic                                is_full
);

    import bmhpq_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UP_RD,
        ST_UP_CMP,
        ST_DN_RD0,
        ST_DN_TAKE,
        ST_DN_RD,
        ST_DN_CMP,
        ST_DONE
    } state_t;

    state_t                state_reg, state_next;
    logic [CNT_BITS-1:0]   count_reg, count_next;
    logic [IDX_BITS-1:0]   pos_reg, pos_next;
    entry_t                item_reg, item_next;
    logic [PRIO_BITS-1:0]  res_prio_reg, res_prio_next;
    logic [DATA_BITS-1:0]  res_data_reg, res_data_next;
    logic [1:0]            res_status_reg, res_status_next;
    logic                  out_valid_reg, out_valid_next;
    logic [PRIO_BITS-1:0]  out_prio_reg, out_prio_next;
    logic [DATA_BITS-1:0]  out_data_reg, out_data_next;
    logic [1:0]            out_status_reg, out_status_next;
    logic [CNT_BITS-1:0]   out_count_reg, out_count_next;
    logic                  out_empty_reg, out_empty_next;
    logic                  out_full_reg, out_full_next;

    logic                  ram_we;
    logic [IDX_BITS-1:0]   ram_waddr;
    entry_t                ram_wdata;
    logic [IDX_BITS-1:0]   ram_raddr_a;
    logic [IDX_BITS-1:0]   ram_raddr_b;
    logic [ENTRY_BITS-1:0] ram_rdata_a;
    logic [ENTRY_BITS-1:0] ram_rdata_b;
    entry_t                rd_a;
    entry_t                rd_b;

    logic                  out_free;
    logic [IDX_BITS-1:0]   pos_dec;
    logic [IDX_BITS-1:0]   parent_idx;
    logic [IDX_BITS-1:0]   last_idx;
    logic [IDX_BITS+1:0]   child_l;
    logic [IDX_BITS+1:0]   child_r;
    logic [IDX_BITS+1:0]   count_ext;
    logic                  take_l;
    logic                  take_r;
    logic [PRIO_BITS-1:0]  best_prio;

    bmhpq_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (ram_raddr_a),
        .raddr_b (ram_raddr_b),
        .rdata_a (ram_rdata_a),
        .rdata_b (ram_rdata_b)
    );

    assign rd_a       = entry_t'(ram_rdata_a);
    assign rd_b       = entry_t'(ram_rdata_b);
    assign out_free   = !out_valid_reg || !out_stall;
    assign pos_dec    = pos_reg - IDX_BITS'(1);
    assign parent_idx = pos_dec >> 1;
    assign last_idx   = IDX_BITS'(count_reg - CNT_BITS'(1));
    assign child_l    = {1'b0, pos_reg, 1'b1};
    assign child_r    = child_l + (IDX_BITS + 2)'(1);
    assign count_ext  = (IDX_BITS + 2)'(count_reg);
    assign take_l     = (child_l < count_ext) && (rd_a.prio > item_reg.prio);
    assign best_prio  = take_l ? rd_a.prio : item_reg.prio;
    assign take_r     = (child_r < count_ext) && (rd_b.prio > best_prio);

    assign in_stall     = (state_reg != ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign out_priority = out_prio_reg;
    assign out_data     = out_data_reg;
    assign status       = out_status_reg;
    assign count        = out_count_reg;
    assign is_empty     = out_empty_reg;
    assign is_full      = out_full_reg;

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        pos_next        = pos_reg;
        item_next       = item_reg;
        res_prio_next   = res_prio_reg;
        res_data_next   = res_data_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg;
        out_prio_next   = out_prio_reg;
        out_data_next   = out_data_reg;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;
        out_empty_next  = out_empty_reg;
        out_full_next   = out_full_reg;
        ram_we          = 1'b0;
        ram_waddr       = pos_reg;
        ram_wdata       = item_reg;
        ram_raddr_a     = parent_idx;
        ram_raddr_b     = last_idx;

        // drop a taken result beat
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (req_type == REQ_ENQ)
                    begin
                        res_prio_next = '0;
                        res_data_next = '0;
                        if (count_reg == COUNT_FULL)
                        begin
                            res_status_next = STATUS_FULL;
                            state_next      = ST_DONE;
                        end
                        else
                        begin
                            res_status_next = STATUS_OK;
                            item_next.prio  = entry_priority;
                            item_next.data  = entry_data;
                            pos_next        = count_reg[IDX_BITS-1:0];
                            count_next      = count_reg + CNT_BITS'(1);
                            state_next      = ST_UP_RD;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        res_prio_next   = '0;
                        res_data_next   = '1;
                        res_status_next = STATUS_EMPTY;
                        state_next      = ST_DONE;
                    end
                    else
                    begin
                        res_status_next = STATUS_OK;
                        state_next      = ST_DN_RD0;
                    end
                end
            end
            ST_UP_RD:
            begin
                if (pos_reg == '0)
                begin
                    ram_we     = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_UP_CMP;
                end
            end
            ST_UP_CMP:
            begin
                ram_we = 1'b1;
                if (item_reg.prio > rd_a.prio)
                begin
                    ram_wdata  = rd_a;
                    pos_next   = parent_idx;
                    state_next = ST_UP_RD;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DN_RD0:
            begin
                ram_raddr_a = '0;
                state_next  = ST_DN_TAKE;
            end
            ST_DN_TAKE:
            begin
                res_prio_next = rd_a.prio;
                res_data_next = rd_a.data;
                item_next     = rd_b;
                count_next    = count_reg - CNT_BITS'(1);
                pos_next      = '0;
                if (count_reg == CNT_BITS'(1))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_DN_RD;
                end
            end
            ST_DN_RD:
            begin
                ram_raddr_a = child_l[IDX_BITS-1:0];
                ram_raddr_b = child_r[IDX_BITS-1:0];
                state_next  = ST_DN_CMP;
            end
            ST_DN_CMP:
            begin
                ram_we = 1'b1;
                if (take_r)
                begin
                    ram_wdata  = rd_b;
                    pos_next   = child_r[IDX_BITS-1:0];
                    state_next = ST_DN_RD;
                end
                else if (take_l)
                begin
                    ram_wdata  = rd_a;
                    pos_next   = child_l[IDX_BITS-1:0];
                    state_next = ST_DN_RD;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_prio_next   = res_prio_reg;
                    out_data_next   = res_data_reg;
                    out_status_next = res_status_reg;
                    out_count_next  = count_reg;
                    out_empty_next  = (count_reg == '0);
                    out_full_next   = (count_reg == COUNT_FULL);
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            pos_reg        <= '0;
            item_reg       <= '0;
            res_prio_reg   <= '0;
            res_data_reg   <= '0;
            res_status_reg <= STATUS_OK;
            out_valid_reg  <= 1'b0;
            out_prio_reg   <= '0;
            out_data_reg   <= '0;
            out_status_reg <= STATUS_OK;
            out_count_reg  <= '0;
            out_empty_reg  <= 1'b1;
            out_full_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            pos_reg        <= pos_next;
            item_reg       <= item_next;
            res_prio_reg   <= res_prio_next;
            res_data_reg   <= res_data_next;
            res_status_reg <= res_status_next;
            out_valid_reg  <= out_valid_next;
            out_prio_reg   <= out_prio_next;
            out_data_reg   <= out_data_next;
            out_status_reg <= out_status_next;
            out_count_reg  <= out_count_next;
            out_empty_reg  <= out_empty_next;
            out_full_reg   <= out_full_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/bmhpq_checker.sv =====
`default_nettype none

`include "binary_max_heap_priority_queue_top_macros.svh"

module bmhpq_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           out_valid,
    input wire logic                           out_stall,
    input wire logic [bmhpq_pkg::PRIO_BITS-1:0] out_priority,
    input wire logic [bmhpq_pkg::DATA_BITS-1:0] out_data,
    input wire logic [1:0]                     status,
    input wire logic [bmhpq_pkg::CNT_BITS-1:0]  count,
    input wire logic                           is_empty,
    input wire logic                           is_full
);

    import bmhpq_pkg::*;

    `BMHPQ_ASSERT_NEXT(a_out_hold, (out_valid && out_stall), (out_valid && $stable(out_data) && $stable(status) && $stable(count)), "stalled result beat changed")

    `BMHPQ_ASSERT_NOW(a_empty_flag, out_valid, (is_empty == (count == '0)), "empty flag disagrees with count")

    `BMHPQ_ASSERT_NOW(a_full_flag, out_valid, ((is_full == (count == COUNT_FULL)) && (count <= COUNT_FULL)), "full flag or count out of range")

    `BMHPQ_ASSERT_NOW(a_empty_deq, (out_valid && (status == STATUS_EMPTY)), ((out_priority == '0) && (out_data == '1) && is_empty), "empty dequeue result malformed")

    `BMHPQ_ASSERT_NOW(a_full_enq, (out_valid && (status == STATUS_FULL)), (is_full && (out_priority == '0) && (out_data == '0)), "dropped enqueue without full heap")

endmodule

bind binary_max_heap_priority_queue_top bmhpq_checker u_bmhpq_checker (.*);

`default_nettype wire
